>>> src/mfvs_pkg.sv
// ----------------------------------------------------------------------------
// mfvs_pkg
// Shared types for the sort-based mode finder: the word passed between the
// cells of the sorting chain and the one-hot controller states.
// ----------------------------------------------------------------------------
package mfvs_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } link_t;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_DRAIN = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

>>> src/mfvs_cell.sv
// ----------------------------------------------------------------------------
// mfvs_cell
// One cell of the systolic insertion sorter. It keeps the smaller of its own
// word and the arriving word and passes the larger one to the right. In shift
// mode it takes the word of its right neighbor instead.
// ----------------------------------------------------------------------------
module mfvs_cell
    import mfvs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  link_t wave_in,
    output link_t wave_out,
    input  link_t right_in,
    output link_t held
);

    logic                     valid_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic                     pass_valid_reg;
    logic signed [DATA_W-1:0] pass_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg      <= right_in.valid;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            pass_valid_reg <= wave_in.valid && valid_reg;
            if (wave_in.valid && !valid_reg)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= right_in.data;
        end
        else if (wave_in.valid)
        begin
            priority if (!valid_reg)
            begin
                data_reg <= wave_in.data;
            end
            else if (wave_in.data < data_reg)
            begin
                data_reg      <= wave_in.data;
                pass_data_reg <= data_reg;
            end
            else
            begin
                pass_data_reg <= wave_in.data;
            end
        end
    end

    assign wave_out = {pass_valid_reg, pass_data_reg};
    assign held     = {valid_reg, data_reg};

endmodule

>>> src/most_frequent_value_by_sorting.sv
// ----------------------------------------------------------------------------
// most_frequent_value_by_sorting
// Collects a set of signed words, sorts them in a chain of cells and scans
// the sorted runs to report the most frequent value, the largest on ties.
// ----------------------------------------------------------------------------
// Channel  Signals                          Direction  Content
// in       in_valid, in_stall               input      value, last_item
// out      out_valid, out_stall             output     mode_value, mode_count
//
// Words are taken one per cycle while loading. After the last word the chain
// settles in the drain state, then shifts the sorted words out in the scan
// state, and the emit state moves the result to the output register. The
// input stalls from the last word until the result enters the output register,
// which waits while that register still holds a stalled result. Reset empties
// every cell and the count.
// ----------------------------------------------------------------------------
module most_frequent_value_by_sorting
    import mfvs_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [DATA_W-1:0]  value,
    input  logic                      last_item,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  mode_value,
    output logic [COUNT_W-1:0]        mode_count
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic                     shift;
    logic                     in_accept;
    logic                     full;
    link_t                    wave   [0:MAX_ITEMS];
    link_t                    stored [0:MAX_ITEMS];

    logic signed [DATA_W-1:0] prev_reg;
    logic [CW-1:0]            run_reg;
    logic [CW-1:0]            best_cnt_reg;
    logic signed [DATA_W-1:0] best_val_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] mode_value_reg;
    logic [COUNT_W-1:0]       mode_count_reg;

    logic                     emit_fire;
    logic [CW-1:0]            final_cnt;
    logic signed [DATA_W-1:0] final_val;
    logic [CW+COUNT_W-1:0]    final_wide;

    assign full      = (fill_reg == CW'(MAX_ITEMS));
    assign in_stall  = (state_reg != ST_LOAD);
    assign in_accept = in_valid && !in_stall;
    assign shift     = (state_reg == ST_SCAN);

    assign wave[0]              = {in_accept && !full, value};
    assign stored[MAX_ITEMS]    = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            mfvs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (shift),
                .wave_in  (wave[gi]),
                .wave_out (wave[gi+1]),
                .right_in (stored[gi+1]),
                .held     (stored[gi])
            );
        end
    endgenerate

    assign emit_fire  = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign final_cnt  = (run_reg >= best_cnt_reg) ? run_reg : best_cnt_reg;
    assign final_val  = (run_reg >= best_cnt_reg) ? prev_reg : best_val_reg;
    assign final_wide = {{COUNT_W{1'b0}}, final_cnt};

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (!full)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    if (last_item)
                    begin
                        state_next = ST_DRAIN;
                        cnt_next   = fill_next;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == fill_reg - CW'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = ST_LOAD;
                    fill_next  = '0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            prev_reg <= stored[0].data;
            priority if (cnt_reg == '0)
            begin
                run_reg      <= CW'(1);
                best_cnt_reg <= '0;
                best_val_reg <= stored[0].data;
            end
            else if (stored[0].data == prev_reg)
            begin
                run_reg <= run_reg + CW'(1);
            end
            else
            begin
                if (run_reg >= best_cnt_reg)
                begin
                    best_cnt_reg <= run_reg;
                    best_val_reg <= prev_reg;
                end
                run_reg <= CW'(1);
            end
        end
        if (emit_fire)
        begin
            mode_value_reg <= final_val;
            mode_count_reg <= final_wide[COUNT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign mode_value = mode_value_reg;
    assign mode_count = mode_count_reg;

endmodule

>>> test/mode_checker.sv
// ----------------------------------------------------------------------------
// mode_checker
// Watches both channels of the mode finder, predicts the result of each set
// and compares it with the word that the block hands over.
// ----------------------------------------------------------------------------
// Every accepted input word is stored in a local copy of the element store,
// up to MAX_ITEMS words per set. When the closing word is accepted the copy is
// sorted ascending and scanned for runs of equal values. The longest run wins,
// and the later run wins a tie. The predicted value and count join a queue.
// Every accepted output word is compared field by field with the oldest
// entry of that queue. The failure count and the number of outstanding
// results are handed to the testbench top.
// ----------------------------------------------------------------------------
module mode_checker
    import mfvs_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic signed [DATA_W-1:0]  value,
    input  logic                      last_item,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [DATA_W-1:0]  mode_value,
    input  logic [COUNT_W-1:0]        mode_count,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
    } mode_t;

    logic signed [DATA_W-1:0] held_words [MAX_ITEMS];
    int                       held_count = 0;
    mode_t                    expected_modes [$];
    mode_t                    oldest_mode;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic predict_mode();
        int                       n;
        int                       i;
        int                       j;
        int                       run;
        int                       best_count;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] best_value;
        mode_t                    result;
        n = held_count;
        for (i = 1; i < n; i++)
        begin
            key = held_words[i];
            j   = i;
            while (j > 0 && held_words[j-1] > key)
            begin
                held_words[j] = held_words[j-1];
                j--;
            end
            held_words[j] = key;
        end
        best_value = held_words[0];
        best_count = 0;
        run        = 1;
        for (i = 1; i <= n; i++)
        begin
            if (i < n && held_words[i] == held_words[i-1])
            begin
                run++;
            end
            else
            begin
                if (run >= best_count)
                begin
                    best_count = run;
                    best_value = held_words[i-1];
                end
                run = 1;
            end
        end
        result.value = best_value;
        result.count = best_count[COUNT_W-1:0];
        expected_modes.push_back(result);
        held_count = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            expected_modes.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_modes.size() == 0)
                begin
                    $error("mode word with no set closed: mode_value %0d, mode_count %0d",
                           mode_value, mode_count);
                    fail_count++;
                end
                else
                begin
                    oldest_mode = expected_modes.pop_front();
                    if (mode_value !== oldest_mode.value)
                    begin
                        $error("mode_value: expected %0d, actual %0d",
                               oldest_mode.value, mode_value);
                        fail_count++;
                    end
                    if (mode_count !== oldest_mode.count)
                    begin
                        $error("mode_count: expected %0d, actual %0d",
                               oldest_mode.count, mode_count);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (held_count < MAX_ITEMS)
                begin
                    held_words[held_count] = value;
                    held_count++;
                end
                if (last_item)
                begin
                    predict_mode();
                end
            end
        end
        pending = expected_modes.size();
    end

endmodule

>>> test/tb_most_frequent_value_by_sorting.sv
// ----------------------------------------------------------------------------
// tb_most_frequent_value_by_sorting
// Stimulus and verdict for the sort-based mode finder.
// ----------------------------------------------------------------------------
// A short directed part covers single-word sets at both extremes, ties that
// must go to the larger value, and a run spread across the set. The random
// part sends mostly small sets drawn from small pools of values, so that runs
// and ties are common, mixed with sets of unrelated values. Both channels idle
// at random; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_most_frequent_value_by_sorting;
    import mfvs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS      = 1024;
    localparam int RANDOM_ITEMS   = 930;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 64;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic signed [DATA_W-1:0]  value     = '0;
    logic                      last_item = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [DATA_W-1:0]  mode_value;
    logic [COUNT_W-1:0]        mode_count;

    int                        fail_count;
    int                        pending;
    int                        idle_cycles = 0;
    int                        stall_hold  = 0;
    int                        stall_pick;
    logic signed [DATA_W-1:0]  set_words [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    most_frequent_value_by_sorting #(
        .MAX_ITEMS (MAX_ITEMS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .mode_value (mode_value),
        .mode_count (mode_count)
    );

    mode_checker #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .mode_value (mode_value),
        .mode_count (mode_count),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall = 1'b0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold = stall_hold - 1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 45)
            begin
                out_stall  = 1'b0;
                stall_hold = $urandom_range(0, 3);
            end
            else if (stall_pick < 80)
            begin
                out_stall  = 1'b1;
                stall_hold = $urandom_range(0, 3);
            end
            else if (stall_pick < 92)
            begin
                out_stall  = 1'b0;
                stall_hold = $urandom_range(20, 80);
            end
            else
            begin
                out_stall  = 1'b1;
                stall_hold = $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic signed [DATA_W-1:0] word, input logic closing,
                             input bit quiet);
        int gap;
        value     = word;
        last_item = closing;
        in_valid  = 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid  = 1'b0;
            value     = $urandom;
            last_item = $urandom_range(0, 1);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_set(input bit quiet);
        int i;
        for (i = 0; i < set_words.size(); i++)
        begin
            send_word(set_words[i], i == set_words.size() - 1, quiet);
        end
        set_words.delete();
    endtask

    task automatic wait_all_modes();
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int                       set_size;
        int                       pool_size;
        int                       random_sent;
        int                       i;
        int                       r;
        bit                       quiet;
        bit                       unrelated;
        logic signed [DATA_W-1:0] pool [8];

        random_sent = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_words = '{32'sh8000_0000};
        send_set(1'b0);
        set_words = '{32'sh7FFF_FFFF};
        send_set(1'b0);
        set_words = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        send_set(1'b1);
        set_words = '{32'sd0, -32'sd1, -32'sd1, 32'sd0, 32'sd5};
        send_set(1'b0);
        set_words = '{32'sd7, 32'sd7, 32'sd7};
        send_set(1'b1);
        set_words = '{-32'sd3, 32'sd2, 32'sd9, -32'sd3};
        send_set(1'b0);
        set_words = '{32'sh5555_5555, 32'shAAAA_AAAA};
        send_set(1'b0);
        wait_all_modes();

        while (random_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                set_size = $urandom_range(1, 16);
            end
            else if (r < 95)
            begin
                set_size = $urandom_range(17, 100);
            end
            else
            begin
                set_size = $urandom_range(101, 300);
            end
            if (set_size > RANDOM_ITEMS - random_sent)
            begin
                set_size = RANDOM_ITEMS - random_sent;
            end
            pool_size = $urandom_range(1, 8);
            for (i = 0; i < pool_size; i++)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    pool[i] = $urandom;
                end
                else
                begin
                    pool[i] = $urandom_range(0, 20) - 10;
                end
            end
            unrelated = ($urandom_range(0, 7) == 0);
            quiet     = ($urandom_range(0, 4) == 0);
            for (i = 0; i < set_size; i++)
            begin
                if (unrelated)
                begin
                    set_words.push_back($urandom);
                end
                else
                begin
                    set_words.push_back(pool[$urandom_range(0, pool_size - 1)]);
                end
            end
            random_sent += set_size;
            send_set(quiet);
            if ($urandom_range(0, 9) == 0)
            begin
                wait_all_modes();
            end
        end

        in_valid = 1'b0;
        wait_all_modes();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/mfvs_pkg.sv
src/mfvs_cell.sv
src/most_frequent_value_by_sorting.sv
test/mode_checker.sv
test/tb_most_frequent_value_by_sorting.sv
